### rtl/cvl_pkg.sv
package cvl_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int POS_W        = 5;
  localparam int COUNT_W      = 5;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_POP    = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

endpackage

### rtl/cvl_ctrl.sv
module cvl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  cvl_pkg::dp_sts_t sts,
  output cvl_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts.out_busy) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/cvl_datapath.sv
module cvl_datapath #(
  parameter int CAPACITY = cvl_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cvl_pkg::dp_cmd_t                   cmd,
  output cvl_pkg::dp_sts_t                   sts,
  input  logic [1:0]                         operation,
  input  logic signed [cvl_pkg::VALUE_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               found,
  output logic [cvl_pkg::POS_W-1:0]          position,
  output logic signed [cvl_pkg::VALUE_W-1:0] popped_value,
  output logic [cvl_pkg::COUNT_W-1:0]        entry_count,
  output logic                               is_empty,
  output logic                               is_full,
  output logic [1:0]                         status
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  logic signed [cvl_pkg::VALUE_W-1:0] cells [CAPACITY];
  logic [CntW-1:0]                    count;
  logic [CntW-1:0]                    count_next;
  logic [CAPACITY-1:0]                match;
  cvl_pkg::op_t                       op_r;
  logic signed [cvl_pkg::VALUE_W-1:0] value_r;

  logic [IdxW-1:0]                    first_idx;
  logic                               hit;
  logic [CntW-1:0]                    count_m1;
  logic [CntW:0]                      pos_full;
  cvl_pkg::status_t                   st_next;
  logic                               found_next;
  logic signed [cvl_pkg::VALUE_W-1:0] popped_next;
  logic                               do_append;
  logic                               do_delete;
  cvl_pkg::status_t                   status_r;

  assign sts.out_busy = out_valid && out_stall;
  assign count_m1     = count - CntW'(1);
  assign hit          = |match;

  // first matching cell
  always_comb begin
    first_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        first_idx = IdxW'(i);
      end
    end
  end

  assign pos_full = {1'b0, CntW'(first_idx)} + (CntW + 1)'(1);

  always_comb begin
    count_next  = count;
    st_next     = cvl_pkg::ST_OK;
    found_next  = 1'b0;
    popped_next = '0;
    do_append   = 1'b0;
    do_delete   = 1'b0;
    unique case (op_r)
      cvl_pkg::OP_APPEND: begin
        if (count == CapCnt) begin
          st_next = cvl_pkg::ST_FULL;
        end else begin
          do_append  = 1'b1;
          count_next = count + CntW'(1);
        end
      end
      cvl_pkg::OP_DELETE: begin
        if (hit) begin
          found_next = 1'b1;
          do_delete  = 1'b1;
          count_next = count_m1;
        end else begin
          st_next = cvl_pkg::ST_MISSING;
        end
      end
      cvl_pkg::OP_POP: begin
        if (count == '0) begin
          st_next = cvl_pkg::ST_EMPTY;
        end else begin
          count_next  = count_m1;
          popped_next = cells[count_m1[IdxW-1:0]];
        end
      end
      cvl_pkg::OP_SEARCH: begin
        if (hit) begin
          found_next = 1'b1;
        end else begin
          st_next = cvl_pkg::ST_MISSING;
        end
      end
    endcase
  end

  // compare cells against the incoming value on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= cvl_pkg::op_t'(operation);
      value_r <= value;
      for (int i = 0; i < CAPACITY; i++) begin
        match[i] <= (cells[i] == value) && (CntW'(i) < count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (do_append) begin
        cells[count[IdxW-1:0]] <= value_r;
      end
      if (do_delete) begin
        for (int i = 0; i < CAPACITY - 1; i++) begin
          if (IdxW'(i) >= first_idx) begin
            cells[i] <= cells[i + 1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      found        <= found_next;
      position     <= found_next ? cvl_pkg::POS_W'(pos_full) : '0;
      popped_value <= popped_next;
      entry_count  <= cvl_pkg::COUNT_W'(count_next);
      is_empty     <= (count_next == '0);
      is_full      <= (count_next == CapCnt);
      status_r     <= st_next;
    end
  end

  assign status = status_r;

endmodule

### rtl/compacting_value_list.sv
// an input transfer registers the item and its match flags, then the result is written
// to the output register once it is free; no new item is taken until that write is done
// a finished result waits in the output register while the next item is taken
// reset (rst, synchronous): clears the entry count and both handshakes
// entry storage is not reset; only entries below the count are ever used
module compacting_value_list #(
  parameter int CAPACITY = cvl_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         operation,
  input  logic signed [cvl_pkg::VALUE_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               found,
  output logic [cvl_pkg::POS_W-1:0]          position,
  output logic signed [cvl_pkg::VALUE_W-1:0] popped_value,
  output logic [cvl_pkg::COUNT_W-1:0]        entry_count,
  output logic                               is_empty,
  output logic                               is_full,
  output logic [1:0]                         status
);

  cvl_pkg::dp_cmd_t cmd;
  cvl_pkg::dp_sts_t sts;

  cvl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cvl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .operation    (operation),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .position     (position),
    .popped_value (popped_value),
    .entry_count  (entry_count),
    .is_empty     (is_empty),
    .is_full      (is_full),
    .status       (status)
  );

endmodule
